@@ hw/rtl/trpe_pkg.sv @@
`default_nettype none

package trpe_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned CoordW    = 12;
  localparam int unsigned LimitW    = 13;
  localparam int unsigned CountW    = 3;
  localparam int unsigned PosW      = 7;
  localparam int unsigned NibbleW   = 4;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned SlotIdxW  = 5;

  localparam logic [ByteW-1:0]    TypeReport  = 8'hFF;
  localparam logic [PosW-1:0]     PosType     = 7'd2;
  localparam logic [PosW-1:0]     PosCounts   = 7'd3;
  localparam logic [PosW-1:0]     PosFirstSlot = 7'd4;
  localparam logic [PhaseW-1:0]   PhaseXLow   = 3'd0;
  localparam logic [PhaseW-1:0]   PhaseYLow   = 3'd1;
  localparam logic [PhaseW-1:0]   PhaseStrength = 3'd2;
  localparam logic [PhaseW-1:0]   PhaseHigh   = 3'd3;
  localparam logic [PhaseW-1:0]   PhaseLast   = 3'd4;
  localparam logic [SlotIdxW-1:0] SlotIdxMax  = 5'd31;
  localparam logic [LimitW-1:0]   LimitReset  = 13'd4096;

  // Register indexes, taken from paddr[2].
  localparam logic RegXLimit = 1'b0;
  localparam logic RegYLimit = 1'b1;

  // Queue between the parser and the result serializer.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;
  localparam int unsigned QueueCntW  = 3;

  localparam int unsigned OutDataW = 40;

  typedef struct packed {
    logic                has_point;
    logic                has_summary;
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [ByteW-1:0]    strength;
    logic [CountW-1:0]   slot;
    logic [CountW-1:0]   total;
  } entry_t;

endpackage

`default_nettype wire

@@ hw/rtl/trpe_front.sv @@
`default_nettype none

module trpe_front #(
  parameter int unsigned MAX_POINTS  = 5,
  parameter int unsigned FRAME_BYTES = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [trpe_pkg::ByteW-1:0]    byte_i,
  input  wire logic                          end_i,
  input  wire logic [trpe_pkg::LimitW-1:0]   x_limit_i,
  input  wire logic [trpe_pkg::LimitW-1:0]   y_limit_i,
  output logic                               push_o,
  output trpe_pkg::entry_t                   entry_o
);

  logic [trpe_pkg::PosW-1:0]     pos_q, pos_d;
  logic                          type_ok_q, type_ok_d;
  logic [trpe_pkg::NibbleW-1:0]  fingers_q, fingers_d;
  logic [trpe_pkg::NibbleW-1:0]  keys_q, keys_d;
  logic [trpe_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic [trpe_pkg::SlotIdxW-1:0] slot_q, slot_d;
  logic [trpe_pkg::ByteW-1:0]    xlo_q, xlo_d;
  logic [trpe_pkg::ByteW-1:0]    ylo_q, ylo_d;
  logic [trpe_pkg::ByteW-1:0]    str_q, str_d;
  logic [trpe_pkg::CountW-1:0]   acc_q, acc_d;

  logic [trpe_pkg::SlotIdxW-1:0] finger_idx;
  logic                          is_finger;
  logic [trpe_pkg::CoordW-1:0]   pt_x, pt_y;
  logic                          emit_point;

  assign finger_idx = slot_q - {1'b0, keys_q};
  assign is_finger  = (slot_q >= {1'b0, keys_q}) && (finger_idx < {1'b0, fingers_q});
  assign pt_x       = {byte_i[3:0], xlo_q};
  assign pt_y       = {byte_i[7:4], ylo_q};

  always_comb begin
    pos_d      = pos_q;
    type_ok_d  = type_ok_q;
    fingers_d  = fingers_q;
    keys_d     = keys_q;
    phase_d    = phase_q;
    slot_d     = slot_q;
    xlo_d      = xlo_q;
    ylo_d      = ylo_q;
    str_d      = str_q;
    acc_d      = acc_q;
    emit_point = 1'b0;

    if (accept_i && (pos_q < trpe_pkg::PosW'(FRAME_BYTES))) begin
      if (pos_q == trpe_pkg::PosType) begin
        type_ok_d = (byte_i == trpe_pkg::TypeReport);
      end else if (pos_q == trpe_pkg::PosCounts) begin
        fingers_d = byte_i[3:0];
        keys_d    = byte_i[7:4];
        phase_d   = '0;
        slot_d    = '0;
      end else if (pos_q >= trpe_pkg::PosFirstSlot) begin
        if (is_finger) begin
          case (phase_q)
            trpe_pkg::PhaseXLow:     xlo_d = byte_i;
            trpe_pkg::PhaseYLow:     ylo_d = byte_i;
            trpe_pkg::PhaseStrength: str_d = byte_i;
            trpe_pkg::PhaseHigh: begin
              if (type_ok_q && (acc_q < trpe_pkg::CountW'(MAX_POINTS)) &&
                  ({1'b0, pt_x} < x_limit_i) && ({1'b0, pt_y} < y_limit_i) &&
                  (str_q != '0)) begin
                emit_point = 1'b1;
                acc_d      = acc_q + 1'b1;
              end
            end
            default: ;
          endcase
        end
        if (phase_q == trpe_pkg::PhaseLast) begin
          phase_d = '0;
          if (slot_q < trpe_pkg::SlotIdxMax) begin
            slot_d = slot_q + 1'b1;
          end
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end
      pos_d = pos_q + 1'b1;
    end

    entry_o.has_point   = emit_point;
    entry_o.has_summary = end_i;
    entry_o.x           = pt_x;
    entry_o.y           = pt_y;
    entry_o.strength    = str_q;
    entry_o.slot        = acc_q;
    entry_o.total       = (type_ok_d && (fingers_d != '0)) ? acc_d : '0;
    push_o              = accept_i && (emit_point || end_i);

    // The frame end returns all frame state to its cleared value.
    if (accept_i && end_i) begin
      pos_d     = '0;
      type_ok_d = 1'b0;
      fingers_d = '0;
      keys_d    = '0;
      phase_d   = '0;
      slot_d    = '0;
      xlo_d     = '0;
      ylo_d     = '0;
      str_d     = '0;
      acc_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      type_ok_q <= 1'b0;
      fingers_q <= '0;
      keys_q    <= '0;
      phase_q   <= '0;
      slot_q    <= '0;
      xlo_q     <= '0;
      ylo_q     <= '0;
      str_q     <= '0;
      acc_q     <= '0;
    end else begin
      pos_q     <= pos_d;
      type_ok_q <= type_ok_d;
      fingers_q <= fingers_d;
      keys_q    <= keys_d;
      phase_q   <= phase_d;
      slot_q    <= slot_d;
      xlo_q     <= xlo_d;
      ylo_q     <= ylo_d;
      str_q     <= str_d;
      acc_q     <= acc_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/trpe_queue.sv @@
`default_nettype none

module trpe_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire trpe_pkg::entry_t entry_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  nonempty_o,
  output trpe_pkg::entry_t      head_o
);

  trpe_pkg::entry_t                mem_q [trpe_pkg::QueueDepth];
  logic [trpe_pkg::QueuePtrW-1:0]  wr_q, wr_d;
  logic [trpe_pkg::QueuePtrW-1:0]  rd_q, rd_d;
  logic [trpe_pkg::QueueCntW-1:0]  cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o     = (cnt_q == trpe_pkg::QueueCntW'(trpe_pkg::QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/trpe_back.sv @@
`default_nettype none

module trpe_back #(
  parameter int unsigned MAX_POINTS = 5
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             nonempty_i,
  input  wire trpe_pkg::entry_t                 head_i,
  output logic                                  pop_o,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [trpe_pkg::OutDataW-1:0]         m_axis_tdata,
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tlast
);

  logic                              valid_q, valid_d;
  logic                              summ_q, summ_d;
  logic                              last_q, last_d;
  logic [trpe_pkg::CoordW-1:0]       x_q, x_d;
  logic [trpe_pkg::CoordW-1:0]       y_q, y_d;
  logic [trpe_pkg::ByteW-1:0]        str_q, str_d;
  logic [trpe_pkg::CountW-1:0]       slot_q, slot_d;
  logic [trpe_pkg::CountW-1:0]       total_q, total_d;
  logic                              point_done_q, point_done_d;
  logic                              load;

  // The output register takes a new beat whenever it is empty or being drained.
  assign load = !valid_q || m_axis_tready;

  always_comb begin
    valid_d      = valid_q;
    summ_d       = summ_q;
    last_d       = last_q;
    x_d          = x_q;
    y_d          = y_q;
    str_d        = str_q;
    slot_d       = slot_q;
    total_d      = total_q;
    point_done_d = point_done_q;
    pop_o        = 1'b0;
    if (load) begin
      valid_d = nonempty_i;
      if (nonempty_i) begin
        if (head_i.has_point && !point_done_q) begin
          summ_d  = 1'b0;
          last_d  = !head_i.has_summary;
          x_d     = head_i.x;
          y_d     = head_i.y;
          str_d   = head_i.strength;
          slot_d  = head_i.slot;
          total_d = '0;
          if (head_i.has_summary) begin
            point_done_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          summ_d       = 1'b1;
          last_d       = 1'b1;
          x_d          = '0;
          y_d          = '0;
          str_d        = '0;
          slot_d       = '0;
          total_d      = head_i.total;
          point_done_d = 1'b0;
          pop_o        = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      point_done_q <= 1'b0;
    end else begin
      valid_q      <= valid_d;
      point_done_q <= point_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    summ_q  <= summ_d;
    last_q  <= last_d;
    x_q     <= x_d;
    y_q     <= y_d;
    str_q   <= str_d;
    slot_q  <= slot_d;
    total_q <= total_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = summ_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {2'b00, total_q, slot_q, str_q, y_q, x_q};

  a_summary_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && summ_q) |-> last_q)
    else $error("summary beat without tlast");

  a_point_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !summ_q) |-> (slot_q < trpe_pkg::CountW'(MAX_POINTS)))
    else $error("point slot beyond point limit");

  a_split_entry_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_done_q |-> (nonempty_i && head_i.has_summary))
    else $error("half-sent entry left the queue");

  a_point_before_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_done_q |-> (valid_q && !summ_q && !last_q))
    else $error("split entry lost its point beat");

endmodule

`default_nettype wire

@@ hw/rtl/touch_report_point_extract_core.sv @@
`default_nettype none

// Touch report point extractor. Report bytes enter on the s_axis side, one
// beat per byte, with tlast on the final byte of a frame. The parser takes
// one byte per cycle and writes each result-causing byte into a four-entry queue;
// the serializer behind it sends one result beat per ready cycle on the m_axis
// side, a point beat (tuser low) for each accepted finger and a summary beat
// (tuser high, point count in tdata) at the frame end, tlast marking the last
// beat caused by a byte. The input side stalls only while that queue is full,
// which happens when the output is held off or when frame-end bytes that also
// complete a finger need two beats. Limits are written over APB at byte
// address 0 (x) and 4 (y) by the user, only while idle (not enforced).
module touch_report_point_extract_core #(
  parameter int unsigned MAX_POINTS  = 5,
  parameter int unsigned FRAME_BYTES = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // report_byte[7:0]
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // point_x[11:0], point_y[23:12], point_strength[31:24], point_slot[34:32],
  // point_total[37:35], zero[39:38]
  output logic [trpe_pkg::OutDataW-1:0]          m_axis_tdata,
  output logic                                   m_axis_tuser,  // is_summary
  output logic                                   m_axis_tlast,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  logic [trpe_pkg::LimitW-1:0] x_limit_q, y_limit_q;
  logic                        cfg_wr;
  logic                        accept;
  logic                        push, pop, full, nonempty;
  trpe_pkg::entry_t            entry, head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_limit_q <= trpe_pkg::LimitReset;
      y_limit_q <= trpe_pkg::LimitReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        trpe_pkg::RegXLimit: x_limit_q <= pwdata[trpe_pkg::LimitW-1:0];
        trpe_pkg::RegYLimit: y_limit_q <= pwdata[trpe_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      trpe_pkg::RegXLimit: prdata = {19'd0, x_limit_q};
      trpe_pkg::RegYLimit: prdata = {19'd0, y_limit_q};
      default:             prdata = '0;
    endcase
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  trpe_front #(
    .MAX_POINTS  (MAX_POINTS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .byte_i    (s_axis_tdata),
    .end_i     (s_axis_tlast),
    .x_limit_i (x_limit_q),
    .y_limit_i (y_limit_q),
    .push_o    (push),
    .entry_o   (entry)
  );

  trpe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (entry),
    .pop_i      (pop),
    .full_o     (full),
    .nonempty_o (nonempty),
    .head_o     (head)
  );

  trpe_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nonempty_i    (nonempty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ tb/touch_report_point_extract_core_tb.sv @@
module touch_report_point_extract_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPoints  = 5;
  localparam int FrameBytes = 64;
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 16;

  typedef struct {
    logic                        summary;
    logic [trpe_pkg::CoordW-1:0] x;
    logic [trpe_pkg::CoordW-1:0] y;
    logic [trpe_pkg::ByteW-1:0]  strength;
    logic [trpe_pkg::CountW-1:0] slot;
    logic [trpe_pkg::CountW-1:0] total;
    logic                        last;
  } touch_beat_t;

  logic                          clk_i;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = 8'd0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [trpe_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;
  logic                          psel          = 1'b0;
  logic                          penable       = 1'b0;
  logic                          pwrite        = 1'b0;
  logic [2:0]                    paddr         = 3'd0;
  logic [31:0]                   pwdata        = 32'd0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Predicted copy of the block's frame state and limits.
  logic [trpe_pkg::PosW-1:0]     rpt_pos      = '0;
  logic                          rpt_type_ok  = 1'b0;
  logic [trpe_pkg::NibbleW-1:0]  rpt_fingers  = '0;
  logic [trpe_pkg::NibbleW-1:0]  rpt_keys     = '0;
  logic [trpe_pkg::PhaseW-1:0]   rpt_phase    = '0;
  logic [trpe_pkg::SlotIdxW-1:0] rpt_slot     = '0;
  logic [trpe_pkg::ByteW-1:0]    rpt_x_lo     = '0;
  logic [trpe_pkg::ByteW-1:0]    rpt_y_lo     = '0;
  logic [trpe_pkg::ByteW-1:0]    rpt_strength = '0;
  logic [trpe_pkg::CountW-1:0]   rpt_accepted = '0;
  logic [trpe_pkg::LimitW-1:0]   x_lim        = trpe_pkg::LimitReset;
  logic [trpe_pkg::LimitW-1:0]   y_lim        = trpe_pkg::LimitReset;

  touch_beat_t expected_beats[$];
  int          err_count       = 0;
  int          readback_errors = 0;
  int          bytes_sent      = 0;
  int          cycles          = 0;
  bit          quiet           = 1'b0;
  int          hold_req        = 0;
  int          hold_len        = 0;

  touch_report_point_extract_core #(
    .MAX_POINTS (MaxPoints),
    .FRAME_BYTES(FrameBytes)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [trpe_pkg::CoordW-1:0] pick_coord(
      input logic [trpe_pkg::LimitW-1:0] lim);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 12'hFFF;
      4:       return 12'(lim - 13'd1);
      5:       return lim[trpe_pkg::CoordW-1:0];
      default: return 12'($urandom);
    endcase
  endfunction

  // Advances the predicted frame state by one report byte and queues the
  // point and summary beats that byte produces.
  task automatic extract_byte(input logic [7:0] b, input logic last);
    touch_beat_t                 pt;
    touch_beat_t                 sm;
    logic                        got_pt;
    logic [trpe_pkg::CoordW-1:0] x;
    logic [trpe_pkg::CoordW-1:0] y;
    pt = '{default: '0};
    sm = '{default: '0};
    got_pt = 1'b0;
    if (rpt_pos < FrameBytes) begin
      if (rpt_pos == trpe_pkg::PosType) begin
        rpt_type_ok = (b == trpe_pkg::TypeReport);
      end else if (rpt_pos == trpe_pkg::PosCounts) begin
        rpt_fingers = b[3:0];
        rpt_keys    = b[7:4];
        rpt_phase   = trpe_pkg::PhaseXLow;
        rpt_slot    = '0;
      end else if (rpt_pos >= trpe_pkg::PosFirstSlot) begin
        if (rpt_slot >= {1'b0, rpt_keys} &&
            (rpt_slot - {1'b0, rpt_keys}) < {1'b0, rpt_fingers}) begin
          case (rpt_phase)
            trpe_pkg::PhaseXLow:     rpt_x_lo = b;
            trpe_pkg::PhaseYLow:     rpt_y_lo = b;
            trpe_pkg::PhaseStrength: rpt_strength = b;
            trpe_pkg::PhaseHigh: begin
              x = {b[3:0], rpt_x_lo};
              y = {b[7:4], rpt_y_lo};
              if (rpt_type_ok && rpt_accepted < MaxPoints && {1'b0, x} < x_lim &&
                  {1'b0, y} < y_lim && rpt_strength != 0) begin
                pt.x        = x;
                pt.y        = y;
                pt.strength = rpt_strength;
                pt.slot     = rpt_accepted;
                got_pt      = 1'b1;
                rpt_accepted = rpt_accepted + 3'd1;
              end
            end
            default: ;
          endcase
        end
        if (rpt_phase == trpe_pkg::PhaseLast) begin
          rpt_phase = trpe_pkg::PhaseXLow;
          if (rpt_slot < trpe_pkg::SlotIdxMax) rpt_slot = rpt_slot + 5'd1;
        end else begin
          rpt_phase = rpt_phase + 3'd1;
        end
      end
      rpt_pos = rpt_pos + 7'd1;
    end
    if (last) begin
      sm.summary = 1'b1;
      sm.total   = (rpt_type_ok && rpt_fingers != 0) ? rpt_accepted : '0;
      sm.last    = 1'b1;
      rpt_pos      = '0;
      rpt_type_ok  = 1'b0;
      rpt_fingers  = '0;
      rpt_keys     = '0;
      rpt_phase    = '0;
      rpt_slot     = '0;
      rpt_x_lo     = '0;
      rpt_y_lo     = '0;
      rpt_strength = '0;
      rpt_accepted = '0;
    end else begin
      pt.last = 1'b1;
    end
    if (got_pt) expected_beats.push_back(pt);
    if (last) expected_beats.push_back(sm);
  endtask

  // Offers one report byte after a random gap and waits for its beat.
  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    bit took;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      if (took) extract_byte(b, last);
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
  endtask

  // Waits until all results are in and the parser has settled.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes one limit register, then reads it back.
  task automatic write_limit(input logic sel, input logic [trpe_pkg::LimitW-1:0] value);
    bit          rdy;
    logic [31:0] rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {19'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    if (sel == trpe_pkg::RegXLimit) x_lim = value;
    else y_lim = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      rd  = prdata;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {19'd0, value}) begin
      $error("limit readback at %0d: expected %0d, got %0d", {sel, 2'b00}, value, rd);
      readback_errors++;
    end
  endtask

  // Sends one report with the given type and counts. Finger coordinates lean
  // toward the current limits, and the frame may end early, exactly on the
  // last finger's high byte, on a group boundary, or run past the slots.
  task automatic send_report(input logic [7:0] kind, input int keys, input int fingers);
    int                          full;
    int                          len;
    int                          grp;
    int                          ph;
    logic [trpe_pkg::CoordW-1:0] fx;
    logic [trpe_pkg::CoordW-1:0] fy;
    logic [trpe_pkg::ByteW-1:0]  fs;
    logic [trpe_pkg::ByteW-1:0]  b;
    full = 4 + (keys + fingers) * 5;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: len = full;
      5, 6:          len = full - 1;
      7:             len = $urandom_range(1, full);
      default:       len = full + $urandom_range(1, 20);
    endcase
    fx = '0;
    fy = '0;
    fs = '0;
    for (int p = 0; p < len; p++) begin
      b = 8'($urandom);
      if (p == 2) begin
        b = kind;
      end else if (p == 3) begin
        b = {keys[3:0], fingers[3:0]};
      end else if (p >= 4) begin
        grp = (p - 4) / 5;
        ph  = (p - 4) % 5;
        if (grp >= keys && grp < keys + fingers) begin
          case (ph)
            0: begin
              fx = pick_coord(x_lim);
              fy = pick_coord(y_lim);
              fs = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
              b  = fx[7:0];
            end
            1:       b = fy[7:0];
            2:       b = fs;
            3:       b = {fy[11:8], fx[11:8]};
            default: ;
          endcase
        end
      end
      send_beat(b, p == len - 1);
    end
  endtask

  task automatic send_random_report();
    logic [7:0] kind;
    int         keys;
    int         fingers;
    int         r;
    kind = ($urandom_range(0, 9) == 0) ? 8'($urandom) : trpe_pkg::TypeReport;
    r = $urandom_range(0, 9);
    if (r < 7) keys = 0;
    else if (r < 9) keys = $urandom_range(1, 2);
    else keys = $urandom_range(3, 15);
    fingers = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
    send_report(kind, keys, fingers);
  endtask

  task automatic check_beat();
    touch_beat_t e;
    if (expected_beats.size() == 0) begin
      $error("result beat with nothing expected: tuser %b tdata %h", m_axis_tuser,
             m_axis_tdata);
      err_count++;
      return;
    end
    e = expected_beats.pop_front();
    if (m_axis_tuser !== e.summary) begin
      $error("is_summary: expected %0d, got %0d", e.summary, m_axis_tuser);
      err_count++;
    end
    if (m_axis_tdata[11:0] !== e.x) begin
      $error("point_x: expected %0d, got %0d", e.x, m_axis_tdata[11:0]);
      err_count++;
    end
    if (m_axis_tdata[23:12] !== e.y) begin
      $error("point_y: expected %0d, got %0d", e.y, m_axis_tdata[23:12]);
      err_count++;
    end
    if (m_axis_tdata[31:24] !== e.strength) begin
      $error("point_strength: expected %0d, got %0d", e.strength, m_axis_tdata[31:24]);
      err_count++;
    end
    if (m_axis_tdata[34:32] !== e.slot) begin
      $error("point_slot: expected %0d, got %0d", e.slot, m_axis_tdata[34:32]);
      err_count++;
    end
    if (m_axis_tdata[37:35] !== e.total) begin
      $error("point_total: expected %0d, got %0d", e.total, m_axis_tdata[37:35]);
      err_count++;
    end
    if (m_axis_tdata[39:38] !== 2'b00) begin
      $error("tdata padding: expected 0, got %0d", m_axis_tdata[39:38]);
      err_count++;
    end
    if (m_axis_tlast !== e.last) begin
      $error("last_of_run: expected %0d, got %0d", e.last, m_axis_tlast);
      err_count++;
    end
  endtask

  // Output side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : result_side
    int stall_left;
    int hold_left;
    int hold_seen;
    int g;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    forever begin
      @(negedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_beat();
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          stall_left = g - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  task automatic test_directed();
    // Finger at the coordinate and strength maximum, completed by the frame
    // end byte, so one byte yields a point and the summary.
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    // One-byte frame.
    send_beat(8'hFF, 1'b1);
    // Wrong report type, fifteen keys and one finger, frame cut short inside a key group.
    send_beat(8'h5A, 1'b0);
    send_beat(8'hA5, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hF1, 1'b0);
    send_beat(8'h10, 1'b0);
    send_beat(8'h20, 1'b0);
    send_beat(8'h30, 1'b1);
    // Valid type but no fingers.
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  task automatic test_limits();
    logic [trpe_pkg::LimitW-1:0] xs[6];
    logic [trpe_pkg::LimitW-1:0] ys[6];
    xs = '{13'd0, 13'd4096, 13'd1, 13'd4095, 13'($urandom_range(0, 4096)), 13'd4096};
    ys = '{13'd4096, 13'd0, 13'd4095, 13'd1, 13'($urandom_range(0, 4096)), 13'd4096};
    for (int i = 0; i < 6; i++) begin
      wait_idle();
      write_limit(trpe_pkg::RegXLimit, xs[i]);
      write_limit(trpe_pkg::RegYLimit, ys[i]);
      repeat (2) send_report(trpe_pkg::TypeReport, $urandom_range(0, 1), $urandom_range(1, 6));
    end
  endtask

  // The output is held off while full-rate reports keep coming, so the
  // result queue fills and the input side has to stall.
  task automatic test_pressure();
    wait_idle();
    quiet    = 1'b1;
    hold_len = 400;
    hold_req++;
    repeat (3) send_report(trpe_pkg::TypeReport, 0, 5);
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int start;
    int last_cfg;
    int n;
    start    = bytes_sent;
    last_cfg = bytes_sent;
    while (bytes_sent - start < 600) begin
      quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) < 8) begin
        send_random_report();
      end else begin
        // Loose bytes with stray frame ends.
        n = $urandom_range(3, 40);
        for (int i = 0; i < n; i++)
          send_beat(8'($urandom), (i == n - 1) || ($urandom_range(0, 29) == 0));
      end
      if (bytes_sent - last_cfg > 300) begin
        quiet = 1'b0;
        wait_idle();
        write_limit(trpe_pkg::RegXLimit, 13'($urandom_range(0, 4096)));
        write_limit(trpe_pkg::RegYLimit, 13'($urandom_range(0, 4096)));
        last_cfg = bytes_sent;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_limits();
    test_pressure();
    test_random();
    wait_idle();
    if (err_count == 0 && readback_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/trpe_pkg.sv
hw/rtl/trpe_front.sv
hw/rtl/trpe_queue.sv
hw/rtl/trpe_back.sv
hw/rtl/touch_report_point_extract_core.sv
tb/touch_report_point_extract_core_tb.sv
